// ===== src/seeded_xxhash64_style_key_hash_macros.svh =====
// Assertion macros shared by the key hash RTL.
`ifndef SEEDED_XXHASH64_STYLE_KEY_HASH_MACROS_SVH
`define SEEDED_XXHASH64_STYLE_KEY_HASH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SXH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key hash check failed");

// The consequent must hold in the cycle after the antecedent.
`define SXH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key hash check failed");

`endif

// ===== src/sxh64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sxh64_pkg;

   localparam logic [63:0] PRIME1     = 64'h9e37_79b1_85eb_ca87;
   localparam logic [63:0] PRIME2     = 64'hc2b2_ae3d_27d4_eb4f;
   localparam logic [63:0] PRIME3     = 64'h1656_67b1_9e37_79f9;
   localparam logic [63:0] SEED_RESET = 64'h9e37_79b9_7f4a_7c15;

   // Sequencer steps. Each step other than idle is one 64-bit multiply.
   typedef logic [3:0] op_type;
   localparam op_type OP_IDLE = 4'd0;
   localparam op_type OP_K1   = 4'd1;  // k = w * P2
   localparam op_type OP_K2   = 4'd2;  // h ^= rotl(k,31) * P1
   localparam op_type OP_H8   = 4'd3;  // h = rotl(h,27) * P1 + P3
   localparam op_type OP_W4   = 4'd4;  // h ^= w[31:0] * P1
   localparam op_type OP_H4   = 4'd5;  // h = rotl(h,23) * P2 + P3
   localparam op_type OP_B    = 4'd6;  // h ^= byte * P3
   localparam op_type OP_HB   = 4'd7;  // h = rotl(h,11) * P1
   localparam op_type OP_A1   = 4'd8;  // k = (h ^ h>>33) * P2
   localparam op_type OP_A2   = 4'd9;  // out = mix of (k ^ k>>29) * P3

   typedef logic [1:0] phase_type;
   localparam phase_type PH_LL = 2'd0;  // low x low, plus addend
   localparam phase_type PH_LH = 2'd1;  // low x high, upper half
   localparam phase_type PH_HL = 2'd2;  // high x low, upper half

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
      rotl64 = (v << n) | (v >> (64 - n));
   endfunction

endpackage

`default_nettype wire

// ===== src/seeded_xxhash64_style_key_hash.sv =====
// Seeded 64-bit key hash on the short-input xxHash64 rounds. Keys stream in as
// little-endian 64-bit words; the word with req_first_word reloads the hash from
// the seed and req_key_length, and the word with req_last_word returns one hash.
// All multiplies run on a single 32x32 multiplier, three passes per 64-bit
// product. After a word is accepted, req_stall stays high until it is mixed:
// three multiplies for 8 bytes, two per byte for 1 to 3 bytes, two plus two
// per byte past the fourth for 4 to 7 bytes, and two more on a last word for
// finalization (a last word with zero bytes takes just those two). A word with
// zero bytes that is not last leaves req_stall low. A waiting result holds the
// finalization until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "seeded_xxhash64_style_key_hash_macros.svh"

module seeded_xxhash64_style_key_hash import sxh64_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_first_word,
   input  wire logic [31:0] req_key_length,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic        req_last_word,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [63:0] rsp_hash_value
);

   op_type      op_ff, op_in;
   phase_type   phase_ff, phase_in;
   logic [63:0] seed_ff;
   logic [63:0] h_ff, h_in;
   logic [63:0] k_ff, k_in;
   logic [63:0] w_ff, w_in;
   logic [3:0]  nb_ff, nb_in;
   logic [2:0]  pos_ff, pos_in;
   logic        last_ff, last_in;
   logic [63:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   logic        accept;
   logic        out_free;
   logic [63:0] opnd_a, opnd_b, addend;
   logic [31:0] mul_x, mul_y;
   logic [63:0] pp;
   logic [63:0] sum;
   logic [63:0] shifted_w;
   logic [3:0]  pos_next;

   assign req_stall      = (op_ff != OP_IDLE);
   assign accept         = req_valid && !req_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign shifted_w      = w_ff >> {pos_ff, 3'b000};
   assign pos_next       = {1'b0, pos_ff} + 4'd1;

   // Operand and constant for the current step.
   always_comb begin
      opnd_a = 64'd0;
      opnd_b = PRIME1;
      addend = 64'd0;
      case (op_ff)
         OP_K1: begin
            opnd_a = w_ff;
            opnd_b = PRIME2;
         end
         OP_K2: opnd_a = rotl64(k_ff, 31);
         OP_H8: begin
            opnd_a = rotl64(h_ff, 27);
            addend = PRIME3;
         end
         OP_W4: opnd_a = {32'd0, w_ff[31:0]};
         OP_H4: begin
            opnd_a = rotl64(h_ff, 23);
            opnd_b = PRIME2;
            addend = PRIME3;
         end
         OP_B: begin
            opnd_a = {56'd0, shifted_w[7:0]};
            opnd_b = PRIME3;
         end
         OP_HB: opnd_a = rotl64(h_ff, 11);
         OP_A1: begin
            opnd_a = h_ff ^ (h_ff >> 33);
            opnd_b = PRIME2;
         end
         OP_A2: begin
            opnd_a = k_ff ^ (k_ff >> 29);
            opnd_b = PRIME3;
         end
         default: opnd_a = 64'd0;
      endcase
   end

   // The low 64 bits of a 64x64 product need three 32x32 partial products;
   // the high x high term falls entirely above bit 63.
   assign mul_x = (phase_ff == PH_HL) ? opnd_a[63:32] : opnd_a[31:0];
   assign mul_y = (phase_ff == PH_LH) ? opnd_b[63:32] : opnd_b[31:0];
   assign pp    = {32'd0, mul_x} * {32'd0, mul_y};
   assign sum   = (phase_ff == PH_LL) ? (pp + addend) : (acc_ff + {pp[31:0], 32'd0});

   always_comb begin
      op_in        = op_ff;
      phase_in     = phase_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      nb_in        = nb_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (op_ff == OP_IDLE) begin
         phase_in = PH_LL;
         if (accept) begin
            if (req_first_word) begin
               h_in = seed_ff + PRIME3 + {32'd0, req_key_length};
            end
            w_in    = req_data_word;
            nb_in   = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
            last_in = req_last_word;
            pos_in  = 3'd0;
            if (req_valid_bytes >= 4'd8) begin
               op_in = OP_K1;
            end else if (req_valid_bytes >= 4'd4) begin
               op_in = OP_W4;
            end else if (req_valid_bytes != 4'd0) begin
               op_in = OP_B;
            end else if (req_last_word) begin
               op_in = OP_A1;
            end
         end
      end else if (phase_ff != PH_HL) begin
         acc_in   = sum;
         phase_in = phase_ff + 2'd1;
      end else if (op_ff != OP_A2 || out_free) begin
         // Last pass: sum is the finished product.
         phase_in = PH_LL;
         case (op_ff)
            OP_K1: begin
               k_in  = sum;
               op_in = OP_K2;
            end
            OP_K2: begin
               h_in  = h_ff ^ sum;
               op_in = OP_H8;
            end
            OP_H8: begin
               h_in  = sum;
               op_in = last_ff ? OP_A1 : OP_IDLE;
            end
            OP_W4: begin
               h_in  = h_ff ^ sum;
               op_in = OP_H4;
            end
            OP_H4: begin
               h_in   = sum;
               pos_in = 3'd4;
               if (nb_ff > 4'd4) begin
                  op_in = OP_B;
               end else begin
                  op_in = last_ff ? OP_A1 : OP_IDLE;
               end
            end
            OP_B: begin
               h_in  = h_ff ^ sum;
               op_in = OP_HB;
            end
            OP_HB: begin
               h_in   = sum;
               pos_in = pos_next[2:0];
               if (pos_next < nb_ff) begin
                  op_in = OP_B;
               end else begin
                  op_in = last_ff ? OP_A1 : OP_IDLE;
               end
            end
            OP_A1: begin
               k_in  = sum;
               op_in = OP_A2;
            end
            OP_A2: begin
               rsp_hash_in  = sum ^ (sum >> 32);
               rsp_valid_in = 1'b1;
               op_in        = OP_IDLE;
            end
            default: op_in = OP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= OP_IDLE;
         phase_ff     <= PH_LL;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_RESET;
      end else begin
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      k_ff        <= k_in;
      w_ff        <= w_in;
      nb_ff       <= nb_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // The multiplier passes only advance while a step is running.
   `SXH_ASSERT_SAME(a_phase_in_step, clock, reset, phase_ff != PH_LL, op_ff != OP_IDLE)
   // A new result only appears at the end of finalization.
   `SXH_ASSERT_SAME(a_rsp_from_final, clock, reset, $rose(rsp_valid_ff), $past(op_ff) == OP_A2)
   // A last word always leads into work that ends in a result.
   `SXH_ASSERT_NEXT(a_last_starts_work, clock, reset, accept && req_last_word, op_ff != OP_IDLE)

endmodule

`default_nettype wire
